### rtl/addressed_command_line_decoder_macros.svh
// assertion macros for the addressed command line decoder
`ifndef ADDRESSED_COMMAND_LINE_DECODER_MACROS_SVH
`define ADDRESSED_COMMAND_LINE_DECODER_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ACLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label failed");

// expression must hold at every clock edge outside reset
`define ACLD_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: label failed");

`endif

### rtl/acld_pkg.sv
// shared types, codes and constants of the addressed command line decoder
`timescale 1ns / 1ps

package acld_pkg;

  localparam int LINE_BUFFER_BYTES_DEFAULT = 64;
  localparam int KEPT_CHARS = 5;

  localparam int BYTE_W  = 8;
  localparam int EVENT_W = 4;
  localparam int INDEX_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W = BYTE_W + EVENT_W + INDEX_W + BYTE_W;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE        = 4'd0,
    EV_PAUSE       = 4'd1,
    EV_RESTART     = 4'd2,
    EV_SWITCH      = 4'd3,
    EV_NOT_OURS    = 4'd4,
    EV_BAD_FORMAT  = 4'd5,
    EV_BAD_COMMAND = 4'd6,
    EV_BAD_INDEX   = 4'd7,
    EV_OVERFLOW    = 4'd8
  } event_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ID_FIRST       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_SECOND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYLIST_COUNT = 2'd2;

  localparam logic [BYTE_W-1:0] ID_FIRST_RESET  = 8'd56;
  localparam logic [BYTE_W-1:0] ID_SECOND_RESET = 8'd49;
  localparam logic [INDEX_W-1:0] PLAYLIST_COUNT_RESET = 4'd4;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CASE_MASK = 8'hdf;

endpackage

### rtl/addressed_command_line_decoder.sv
// addressed command line decoder: per-byte echo and line command decode
// a result is registered and appears in the output register in the cycle after its byte is accepted
// throughput: one byte per cycle unless the output stalls; the output register refills while its result is taken
// every byte gives exactly one result; the line state is one register set updated per byte
// reset: synchronous active-high rst clears the line state and the output valid flag and
// restores the id registers to "81" and the playlist count to 4
`timescale 1ns / 1ps

module addressed_command_line_decoder
  import acld_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = LINE_BUFFER_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // rx_byte[7:0]
  input  logic [BYTE_W-1:0]    s_tdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // echo_byte[7:0], event_res[11:8], playlist_index[15:12], offending_byte[23:16]
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_BYTES - 1);

  logic [BYTE_W-1:0]  id_first;
  logic [BYTE_W-1:0]  id_second;
  logic [INDEX_W-1:0] playlist_count;

  logic [LEN_W-1:0]   line_length, line_length_next;
  logic [BYTE_W-1:0]  leading_chars [KEPT_CHARS];
  logic [BYTE_W-1:0]  leading_chars_next [KEPT_CHARS];
  logic               discarding, discarding_next;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_echo;
  event_t             out_event, event_next;
  logic [INDEX_W-1:0] out_index, index_next;
  logic [BYTE_W-1:0]  out_offend, offend_next;

  logic               accept;
  logic               term;
  logic [BYTE_W-1:0]  ch;
  logic [BYTE_W-1:0]  digit_off;

  assign s_tready  = !rst && (!out_valid || m_tready);
  assign cfg_ready = !rst;
  assign accept    = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_offend, out_index, out_event, out_echo};

  assign term = (s_tdata == CH_CR) || (s_tdata == CH_LF) || (s_tdata == CH_NUL);
  assign digit_off = leading_chars[4] - CH_ZERO;

  always_comb begin
    ch = s_tdata;
    if (term) begin
      ch = CH_NUL;
    end else if (s_tdata >= CH_LOW_A && s_tdata <= CH_LOW_Z) begin
      ch = s_tdata & CASE_MASK;
    end
  end

  always_comb begin
    line_length_next = line_length;
    leading_chars_next = leading_chars;
    discarding_next = discarding;
    event_next = EV_NONE;
    index_next = '0;
    offend_next = '0;
    if (discarding) begin
      if (term) begin
        discarding_next = 1'b0;
        line_length_next = '0;
        for (int i = 0; i < KEPT_CHARS; i++) leading_chars_next[i] = '0;
      end
    end else if (line_length >= LEN_LIMIT) begin
      event_next = EV_OVERFLOW;
      line_length_next = '0;
      for (int i = 0; i < KEPT_CHARS; i++) leading_chars_next[i] = '0;
      discarding_next = !term;
    end else if (term) begin
      line_length_next = '0;
      for (int i = 0; i < KEPT_CHARS; i++) leading_chars_next[i] = '0;
      // unused positions are kept at zero, so short lines read zeros there
      if (leading_chars[0] == CH_NUL) begin
        event_next = EV_NONE;
      end else if (leading_chars[0] != id_first || leading_chars[1] != id_second) begin
        event_next = EV_NOT_OURS;
      end else if (leading_chars[2] != CH_SPACE) begin
        event_next = EV_BAD_FORMAT;
      end else if (leading_chars[3] == CH_P) begin
        event_next = EV_PAUSE;
      end else if (leading_chars[3] == CH_R) begin
        event_next = EV_RESTART;
      end else if (leading_chars[3] == CH_S) begin
        if (leading_chars[4] >= CH_ZERO &&
            digit_off < {{(BYTE_W-INDEX_W){1'b0}}, playlist_count}) begin
          event_next = EV_SWITCH;
          index_next = digit_off[INDEX_W-1:0];
        end else begin
          event_next = EV_BAD_INDEX;
        end
      end else begin
        event_next = EV_BAD_COMMAND;
        offend_next = leading_chars[3];
      end
    end else begin
      for (int i = 0; i < KEPT_CHARS; i++) begin
        if (line_length == LEN_W'(i)) leading_chars_next[i] = ch;
      end
      line_length_next = line_length + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_first <= ID_FIRST_RESET;
      id_second <= ID_SECOND_RESET;
      playlist_count <= PLAYLIST_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ID_FIRST:       id_first <= cfg_data;
        CFG_ID_SECOND:      id_second <= cfg_data;
        CFG_PLAYLIST_COUNT: playlist_count <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      discarding <= 1'b0;
      for (int i = 0; i < KEPT_CHARS; i++) leading_chars[i] <= '0;
    end else if (accept) begin
      line_length <= line_length_next;
      discarding <= discarding_next;
      leading_chars <= leading_chars_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // payload holds while a request waits on the output side
  always_ff @(posedge clk) begin
    if (accept) begin
      out_echo <= s_tdata;
      out_event <= event_next;
      out_index <= index_next;
      out_offend <= offend_next;
    end
  end

endmodule

### rtl/acld_checker.sv
// port-level checker for the addressed command line decoder and its bind
`timescale 1ns / 1ps
`include "addressed_command_line_decoder_macros.svh"

module acld_checker
  import acld_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic [BYTE_W-1:0]    s_tdata,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [OUT_W-1:0]     m_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready
);

  `ACLD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ACLD_ASSERT_ALWAYS(a_ready_when_free, s_tready == (!rst && (!m_tvalid || m_tready)))
  `ACLD_ASSERT_NEXT(a_echo, s_tvalid && s_tready,
                    m_tvalid && m_tdata[BYTE_W-1:0] == $past(s_tdata))
  `ACLD_ASSERT_ALWAYS(a_index_only_on_switch,
                      !m_tvalid || m_tdata[BYTE_W+EVENT_W-1:BYTE_W] == EV_SWITCH ||
                      m_tdata[BYTE_W+EVENT_W+INDEX_W-1:BYTE_W+EVENT_W] == '0)

endmodule

bind addressed_command_line_decoder acld_checker u_acld_checker (.*);
